/* rtl/pbrle_pkg.sv */
// shared types and constants for the packbits run-length encoder
package pbrle_pkg;

  localparam int DEF_MAX_LITERAL = 32;
  localparam int DEF_MAX_REPEAT  = 128;

  localparam logic [7:0] END_CODE = 8'd128;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLOSE,
    ST_RUN_HDR,
    ST_RUN_VAL,
    ST_FL_HDR,
    ST_FL_LIT,
    ST_END,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RET_FIN,
    RET_CLOSE,
    RET_END
  } ret_t;

  typedef enum logic [2:0] {
    EM_RUN_HDR,
    EM_RUN_VAL,
    EM_LIT_HDR,
    EM_LIT,
    EM_END
  } emit_t;

  typedef struct packed {
    logic  accept;
    logic  emit;
    emit_t sel;
    logic  inc_rl;
    logic  push;
    logic  rl_dec;
    logic  set_run;
    logic  rl_clr;
    logic  clr_all;
    logic  lc_clr;
    logic  rd_first;
    logic  rd_next;
    logic  release_held;
  } cmd_t;

  typedef struct packed {
    logic extend;
    logic flush_need;
    logic rl_zero;
    logic rl_one;
    logic rl_ge3;
    logic lc_zero;
    logic push_fills;
    logic lit_last;
    logic fin;
    logic emit_ok;
    logic can_load;
    logic held_v;
  } status_t;

endpackage

/* rtl/pbrle_ctrl.sv */
// sequencer for run, literal and end code emission
module pbrle_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pbrle_pkg::status_t st,
  output pbrle_pkg::cmd_t    cmd
);
  import pbrle_pkg::*;

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;
  ret_t   ret_r, ret_nxt;

  // targets when a run close or a literal flush completes
  state_t cd_state, fr_state, fin_state;
  logic   cd_final, fr_final;
  ret_t   cd_ret;
  logic   close_here;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      ret_r   <= RET_FIN;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign close_here = !st.rl_ge3 && (st.rl_zero || (st.rl_one && !st.push_fills));

  // a pending or just emitted byte still needs its last-of-burst release
  always_comb begin
    fin_state = (st.held_v || (cmd.emit && st.emit_ok)) ? ST_DONE : ST_IDLE;
  end

  always_comb begin
    cd_ret = ret_r;
    if (final_r) begin
      cd_state = ST_FL_HDR;
      cd_final = 1'b1;
      cd_ret   = RET_END;
    end else if (st.fin) begin
      cd_state = ST_CLOSE;
      cd_final = 1'b1;
    end else begin
      cd_state = fin_state;
      cd_final = 1'b0;
    end
  end

  always_comb begin
    fr_final = final_r;
    unique case (ret_r)
      RET_FIN: begin
        if (st.fin) begin
          fr_state = ST_CLOSE;
          fr_final = 1'b1;
        end else begin
          fr_state = fin_state;
        end
      end
      RET_CLOSE: fr_state = ST_CLOSE;
      RET_END:   fr_state = ST_END;
      default:   fr_state = ST_END;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.extend) begin
          if (st.flush_need) begin
            state_nxt = ST_FL_HDR;
            ret_nxt   = RET_FIN;
          end else if (st.fin) begin
            state_nxt = ST_CLOSE;
            final_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_CLOSE;
          final_nxt = 1'b0;
        end
      end
      ST_CLOSE: begin
        if (st.rl_ge3) begin
          state_nxt = ST_RUN_HDR;
        end else if (close_here) begin
          state_nxt = cd_state;
          final_nxt = cd_final;
          ret_nxt   = cd_ret;
        end else if (st.push_fills) begin
          state_nxt = ST_FL_HDR;
          ret_nxt   = RET_CLOSE;
        end
      end
      ST_RUN_HDR: begin
        if (st.emit_ok) state_nxt = ST_RUN_VAL;
      end
      ST_RUN_VAL: begin
        if (st.emit_ok) begin
          state_nxt = cd_state;
          final_nxt = cd_final;
          ret_nxt   = cd_ret;
        end
      end
      ST_FL_HDR: begin
        if (st.lc_zero) begin
          state_nxt = fr_state;
          final_nxt = fr_final;
        end else if (st.emit_ok) begin
          state_nxt = ST_FL_LIT;
        end
      end
      ST_FL_LIT: begin
        if (st.emit_ok && st.lit_last) begin
          state_nxt = fr_state;
          final_nxt = fr_final;
        end
      end
      ST_END: begin
        if (st.emit_ok) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!st.held_v || st.can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.sel = EM_END;
    unique case (state_r)
      ST_IDLE:   cmd.accept = in_valid;
      ST_DECIDE: cmd.inc_rl = st.extend;
      ST_CLOSE: begin
        if (!st.rl_ge3 && !st.rl_zero) begin
          cmd.push   = 1'b1;
          cmd.rl_dec = 1'b1;
        end
        cmd.set_run = close_here && !final_r;
      end
      ST_RUN_HDR: begin
        cmd.emit = 1'b1;
        cmd.sel  = EM_RUN_HDR;
      end
      ST_RUN_VAL: begin
        cmd.emit    = 1'b1;
        cmd.sel     = EM_RUN_VAL;
        cmd.rl_clr  = st.emit_ok;
        cmd.set_run = st.emit_ok && !final_r;
      end
      ST_FL_HDR: begin
        if (!st.lc_zero) begin
          cmd.emit     = 1'b1;
          cmd.sel      = EM_LIT_HDR;
          cmd.rd_first = st.emit_ok;
        end
      end
      ST_FL_LIT: begin
        cmd.emit    = 1'b1;
        cmd.sel     = EM_LIT;
        cmd.lc_clr  = st.emit_ok && st.lit_last;
        cmd.rd_next = st.emit_ok && !st.lit_last;
      end
      ST_END: begin
        cmd.emit    = 1'b1;
        cmd.sel     = EM_END;
        cmd.clr_all = st.emit_ok;
      end
      ST_DONE:   cmd.release_held = 1'b1;
      default:   cmd.accept = 1'b0;
    endcase
  end

endmodule

/* rtl/pbrle_dp.sv */
// run and literal registers, literal memory, hold stage and output register
module pbrle_dp #(
  parameter int MAX_LITERAL = pbrle_pkg::DEF_MAX_LITERAL,
  parameter int MAX_REPEAT  = pbrle_pkg::DEF_MAX_REPEAT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  logic               in_final_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_of_burst,
  input  pbrle_pkg::cmd_t    cmd,
  output pbrle_pkg::status_t st
);
  import pbrle_pkg::*;

  localparam int LC_W  = $clog2(MAX_LITERAL + 1);
  localparam int LCX_W = LC_W + 1;
  localparam int IDX_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

  logic [7:0]       mem [MAX_LITERAL];
  logic [7:0]       mem_q_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] rd_addr;

  logic [7:0]      byte_r;
  logic            fin_r;
  logic [LC_W-1:0] lc_r, lc_nxt;
  logic [7:0]      rv_r, rv_nxt;
  logic [7:0]      rl_r, rl_nxt;

  logic       held_v_r;
  logic [7:0] held_r;
  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;

  logic       can_load, emit_ok, emit_fire, move;
  logic [7:0] emit_data;

  assign can_load  = !out_valid_r || !out_stall;
  assign emit_ok   = !held_v_r || can_load;
  assign emit_fire = cmd.emit && emit_ok;
  assign move      = held_v_r && can_load && (cmd.emit || cmd.release_held);

  always_comb begin
    st.extend     = (rl_r != 8'd0) && (byte_r == rv_r) && (rl_r < 8'(MAX_REPEAT));
    st.flush_need = ((rl_r == 8'd1) &&
                     ((LCX_W'(lc_r) + LCX_W'(2)) > LCX_W'(MAX_LITERAL))) ||
                    (rl_r == 8'd2);
    st.rl_zero    = (rl_r == 8'd0);
    st.rl_one     = (rl_r == 8'd1);
    st.rl_ge3     = (rl_r >= 8'd3);
    st.lc_zero    = (lc_r == '0);
    st.push_fills = (LCX_W'(lc_r) + LCX_W'(1)) == LCX_W'(MAX_LITERAL);
    st.lit_last   = (LCX_W'(idx_r) + LCX_W'(1)) == LCX_W'(lc_r);
    st.fin        = fin_r;
    st.emit_ok    = emit_ok;
    st.can_load   = can_load;
    st.held_v     = held_v_r;
  end

  always_comb begin
    unique case (cmd.sel)
      // 257 - length, taken mod 256
      EM_RUN_HDR: emit_data = 8'd1 - rl_r;
      EM_RUN_VAL: emit_data = rv_r;
      EM_LIT_HDR: emit_data = {{(8 - LC_W){1'b0}}, lc_r - LC_W'(1)};
      EM_LIT:     emit_data = mem_q_r;
      EM_END:     emit_data = END_CODE;
      default:    emit_data = END_CODE;
    endcase
  end

  always_comb begin
    lc_nxt = lc_r;
    rv_nxt = rv_r;
    rl_nxt = rl_r;
    if (cmd.inc_rl) rl_nxt = rl_r + 8'd1;
    if (cmd.rl_dec) rl_nxt = rl_r - 8'd1;
    if (cmd.rl_clr) rl_nxt = 8'd0;
    if (cmd.push)   lc_nxt = lc_r + LC_W'(1);
    if (cmd.lc_clr) lc_nxt = '0;
    if (cmd.set_run) begin
      rv_nxt = byte_r;
      rl_nxt = 8'd1;
    end
    if (cmd.clr_all) begin
      lc_nxt = '0;
      rv_nxt = 8'd0;
      rl_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r <= '0;
      rv_r <= 8'd0;
      rl_r <= 8'd0;
    end else begin
      lc_r <= lc_nxt;
      rv_r <= rv_nxt;
      rl_r <= rl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      fin_r  <= in_final_byte;
    end
  end

  assign rd_addr = cmd.rd_first ? '0 : idx_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.push) mem[lc_r[IDX_W-1:0]] <= rv_r;
    if (cmd.rd_first || cmd.rd_next) begin
      mem_q_r <= mem[rd_addr];
      idx_r   <= rd_addr;
    end
  end

  // one byte held back so the last byte of a request can be flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        held_v_r <= 1'b1;
      end else if (cmd.release_held && can_load) begin
        held_v_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (can_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) held_r <= emit_data;
    if (move) begin
      out_byte_r <= held_r;
      out_last_r <= cmd.release_held;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_burst = out_last_r;

endmodule

/* rtl/packbits_run_length_encoder_unit.sv */
// top level of the packbits run-length encoder
//
// raw bytes enter on the in_ channel (valid/stall), one request per byte,
// in_final_byte marking the last byte of an image. coded bytes leave on the
// out_ channel; out_last_of_burst flags the last byte caused by a request.
// a request that codes nothing produces no output at all.
// one byte is worked on at a time: in_stall is high from the cycle after a
// request until the controller is done with it.
// emission runs one coded byte per cycle, unless out_stall holds it back,
// from a single-port literal memory with registered read: a literal flush
// sends a header and then its n bytes, a repeat code a header and the
// value, and a burst ends with the release of the held byte.
// the end code 128 follows the final byte's flushes.
// synchronous reset clears the run, the literal count and both channels;
// the literal memory needs no clearing, only written entries are read.
// while out_stall holds a valid output, the output register freezes, a full
// hold stage keeps its byte and emission waits; nothing is dropped.
module packbits_run_length_encoder_unit #(
  parameter int MAX_LITERAL = pbrle_pkg::DEF_MAX_LITERAL,
  parameter int MAX_REPEAT  = pbrle_pkg::DEF_MAX_REPEAT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_burst
);
  import pbrle_pkg::*;

  cmd_t    cmd;
  status_t st;

  pbrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pbrle_dp #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_REPEAT  (MAX_REPEAT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_burst (out_last_of_burst),
    .cmd               (cmd),
    .st                (st)
  );

endmodule
